>>> rtl/llft_pkg.sv
// Shared constants and types for the leaf label frequency table.
package llft_pkg;

  localparam int LEAVES_DEF  = 16;
  localparam int ENTRIES_DEF = 32;

  localparam int FUNC_W  = 1;
  localparam int LEAF_W  = 4;
  localparam int LABEL_W = 16;
  localparam int CNT_W   = 32;
  localparam int TOP_W   = 6;

  localparam logic [TOP_W-1:0]  TOP_RESET   = 6'd4;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_RECORD = 1'b1;

  // Result of the shared saturating adder and comparator.
  typedef struct packed {
    logic [CNT_W-1:0] sum;
    logic             lt;
  } alu_rsp_t;

endpackage

>>> rtl/llft_alu.sv
// Shared saturating adder and magnitude comparator for counts and sums.
module llft_alu (
  input  logic [llft_pkg::CNT_W-1:0] a,
  input  logic [llft_pkg::CNT_W-1:0] b,
  output llft_pkg::alu_rsp_t         rsp
);
  import llft_pkg::*;

  logic [CNT_W:0] sum_wide;

  assign sum_wide = {1'b0, a} + {1'b0, b};

  always_comb begin
    rsp.sum = sum_wide[CNT_W] ? {CNT_W{1'b1}} : sum_wide[CNT_W-1:0];
    rsp.lt  = (a < b);
  end

endmodule

>>> rtl/leaf_label_frequency_table.sv
// Per-leaf label lists kept in descending count order, with a shared arithmetic unit.
// A query searches the leaf's list, then sums the first min(len,top_count) counts. A record
// also bumps or appends the label and bubbles it forward before the sum. The entry memory has
// a single read port, which the search, bubble and sum passes walk one entry at a time.
// One item at a time; the result waits in the output register and the next item is taken
// from the following cycle. After reset a clearing pass zeroes the lengths and totals of all
// leaves with input stalled; the top count resets to 4.
module leaf_label_frequency_table #(
  parameter int LEAVES  = llft_pkg::LEAVES_DEF,
  parameter int ENTRIES = llft_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [llft_pkg::TOP_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [llft_pkg::FUNC_W-1:0]   in_func,
  input  logic [llft_pkg::LEAF_W-1:0]   in_leaf,
  input  logic [llft_pkg::LABEL_W-1:0]  in_label,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic                          out_room,
  output logic [llft_pkg::CNT_W-1:0]    out_top_mass,
  output logic [llft_pkg::CNT_W-1:0]    out_leaf_total,
  output logic                          out_dropped
);
  import llft_pkg::*;

  localparam int LAW  = $clog2(LEAVES);
  localparam int IW   = $clog2(ENTRIES);
  localparam int LW   = $clog2(ENTRIES + 1);
  localparam int EAW  = $clog2(LEAVES * ENTRIES);
  localparam int CMPW = (LW > TOP_W) ? LW : TOP_W;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_META = 4'd2;
  localparam logic [3:0] S_SRCH = 4'd3;
  localparam logic [3:0] S_MUT  = 4'd4;
  localparam logic [3:0] S_BRD  = 4'd5;
  localparam logic [3:0] S_BCMP = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_ZERO = 4'd8;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [CNT_W-1:0]   count;
  } entry_t;

  typedef struct packed {
    logic [LW-1:0]    len;
    logic [CNT_W-1:0] events;
  } meta_t;

  function automatic logic [LW-1:0] scan_limit(input logic [LW-1:0] len,
                                               input logic [TOP_W-1:0] tc);
    if (CMPW'(tc) < CMPW'(len)) begin
      return LW'(tc);
    end
    return len;
  endfunction

  // Memories.
  entry_t entry_mem_r [LEAVES*ENTRIES];
  meta_t  meta_mem_r  [LEAVES];
  entry_t entry_q_r;
  meta_t  meta_q_r;

  logic           entry_we;
  logic [EAW-1:0] entry_waddr;
  entry_t         entry_wdata;
  logic [EAW-1:0] entry_raddr;
  logic           meta_we;
  logic [LAW-1:0] meta_waddr;
  meta_t          meta_wdata;
  logic [LAW-1:0] meta_raddr;

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem_r[entry_waddr] <= entry_wdata;
    end
    entry_q_r <= entry_mem_r[entry_raddr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem_r[meta_waddr] <= meta_wdata;
    end
    meta_q_r <= meta_mem_r[meta_raddr];
  end

  // Control state.
  logic [3:0]       state_r, state_nxt;
  logic [LAW-1:0]   clr_r, clr_nxt;
  logic [TOP_W-1:0] top_r;
  logic [LW-1:0]    iss_r, iss_nxt;
  logic             d_vld_r, d_vld_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Item payload and working registers.
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [LABEL_W-1:0] label_r, label_nxt;
  logic [LAW-1:0]     leaf_idx_r, leaf_idx_nxt;
  logic [EAW-1:0]     base_r, base_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic [LW-1:0]      scan_len_r, scan_len_nxt;
  logic [CNT_W-1:0]   events_r, events_nxt;
  logic [CNT_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   mv_count_r, mv_count_nxt;
  logic [IW-1:0]      d_idx_r, d_idx_nxt;
  logic [IW-1:0]      pos_r, pos_nxt;
  logic [IW-1:0]      cur_r, cur_nxt;
  logic               hit_r, hit_nxt;
  logic               room_r, room_nxt;
  logic               found_r, found_nxt;
  logic               dropped_r, dropped_nxt;

  logic               o_hit_r, o_hit_nxt;
  logic               o_room_r, o_room_nxt;
  logic [CNT_W-1:0]   o_mass_r, o_mass_nxt;
  logic [CNT_W-1:0]   o_total_r, o_total_nxt;
  logic               o_drop_r, o_drop_nxt;

  // Shared arithmetic unit.
  logic [CNT_W-1:0] alu_a, alu_b;
  alu_rsp_t         alu_rsp;

  llft_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .rsp (alu_rsp)
  );

  logic         accept;
  logic         out_free;
  logic         scan_done;
  logic         full;
  logic [LW-1:0] len_grown;
  logic [IW-1:0] cur_m1;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_done = !d_vld_r && (iss_r == scan_len_r);
  assign full      = (len_r == LW'(ENTRIES));
  assign len_grown = len_r + LW'(1);
  assign cur_m1    = cur_r - IW'(1);

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      S_SRCH: begin
        alu_a = entry_q_r.count;
        alu_b = CNT_W'(1);
      end
      S_MUT: begin
        alu_a = events_r;
        alu_b = CNT_W'(1);
      end
      S_BCMP: begin
        alu_a = entry_q_r.count;
        alu_b = mv_count_r;
      end
      S_SUM: begin
        alu_a = acc_r;
        alu_b = entry_q_r.count;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    iss_nxt       = iss_r;
    d_vld_nxt     = 1'b0;
    d_idx_nxt     = d_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    func_nxt      = func_r;
    label_nxt     = label_r;
    leaf_idx_nxt  = leaf_idx_r;
    base_nxt      = base_r;
    len_nxt       = len_r;
    scan_len_nxt  = scan_len_r;
    events_nxt    = events_r;
    acc_nxt       = acc_r;
    mv_count_nxt  = mv_count_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    hit_nxt       = hit_r;
    room_nxt      = room_r;
    found_nxt     = found_r;
    dropped_nxt   = dropped_r;
    o_hit_nxt     = o_hit_r;
    o_room_nxt    = o_room_r;
    o_mass_nxt    = o_mass_r;
    o_total_nxt   = o_total_r;
    o_drop_nxt    = o_drop_r;

    entry_we    = 1'b0;
    entry_waddr = base_r;
    entry_wdata = '{label: label_r, count: mv_count_r};
    entry_raddr = base_r;
    meta_we     = 1'b0;
    meta_waddr  = leaf_idx_r;
    meta_wdata  = '{len: len_r, events: events_r};
    meta_raddr  = leaf_idx_r;

    unique case (state_r)
      S_CLR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        meta_wdata = '0;
        clr_nxt    = clr_r + LAW'(1);
        if (clr_r == LAW'(LEAVES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          func_nxt     = in_func;
          label_nxt    = in_label;
          leaf_idx_nxt = LAW'(in_leaf);
          base_nxt     = EAW'(in_leaf) * EAW'(ENTRIES);
          dropped_nxt  = 1'b0;
          meta_raddr   = LAW'(in_leaf);
          if (32'(in_leaf) < LEAVES) begin
            state_nxt = S_META;
          end else begin
            state_nxt = S_ZERO;
          end
        end
      end
      S_META: begin
        len_nxt      = meta_q_r.len;
        events_nxt   = meta_q_r.events;
        room_nxt     = (CMPW'(meta_q_r.len) < CMPW'(top_r));
        scan_len_nxt = meta_q_r.len;
        iss_nxt      = '0;
        hit_nxt      = 1'b0;
        found_nxt    = 1'b0;
        state_nxt    = S_SRCH;
      end
      S_SRCH, S_SUM: begin
        // Reads are issued one entry per cycle; data returns in the next cycle.
        if (iss_r != scan_len_r) begin
          entry_raddr = base_r + EAW'(iss_r);
          d_vld_nxt   = 1'b1;
          d_idx_nxt   = IW'(iss_r);
          iss_nxt     = iss_r + LW'(1);
        end
        if (state_r == S_SRCH) begin
          if (d_vld_r && (entry_q_r.label == label_r)) begin
            if (CMPW'(d_idx_r) < CMPW'(top_r)) begin
              hit_nxt = 1'b1;
            end
            if (!found_r) begin
              found_nxt    = 1'b1;
              pos_nxt      = d_idx_r;
              mv_count_nxt = alu_rsp.sum;
            end
          end
          if (scan_done) begin
            if (func_r == FUNC_QUERY) begin
              scan_len_nxt = scan_limit(len_r, top_r);
              iss_nxt      = '0;
              acc_nxt      = '0;
              state_nxt    = S_SUM;
            end else begin
              state_nxt = S_MUT;
            end
          end
        end else begin
          if (d_vld_r) begin
            acc_nxt = alu_rsp.sum;
          end
          if (scan_done) begin
            d_vld_nxt = 1'b0;
            iss_nxt   = iss_r;
            if (out_free) begin
              out_valid_nxt = 1'b1;
              o_hit_nxt     = hit_r;
              o_room_nxt    = room_r;
              o_mass_nxt    = acc_r;
              o_total_nxt   = events_r;
              o_drop_nxt    = dropped_r;
              state_nxt     = S_IDLE;
            end
          end
        end
      end
      S_MUT: begin
        events_nxt        = alu_rsp.sum;
        meta_we           = 1'b1;
        meta_wdata.events = alu_rsp.sum;
        if (found_r) begin
          cur_nxt   = pos_r;
          state_nxt = S_BRD;
        end else begin
          if (full) begin
            dropped_nxt = 1'b1;
            len_nxt     = len_r;
          end else begin
            entry_we    = 1'b1;
            entry_waddr = base_r + EAW'(len_r);
            entry_wdata = '{label: label_r, count: CNT_W'(1)};
            len_nxt     = len_grown;
          end
          meta_wdata.len = len_nxt;
          scan_len_nxt   = scan_limit(len_nxt, top_r);
          iss_nxt        = '0;
          acc_nxt        = '0;
          state_nxt      = S_SUM;
        end
      end
      S_BRD: begin
        if (cur_r == '0) begin
          entry_we     = 1'b1;
          entry_waddr  = base_r;
          scan_len_nxt = scan_limit(len_r, top_r);
          iss_nxt      = '0;
          acc_nxt      = '0;
          state_nxt    = S_SUM;
        end else begin
          entry_raddr = base_r + EAW'(cur_m1);
          state_nxt   = S_BCMP;
        end
      end
      S_BCMP: begin
        // A smaller neighbor slides back one place; otherwise the moving entry lands here.
        entry_we    = 1'b1;
        entry_waddr = base_r + EAW'(cur_r);
        if (alu_rsp.lt) begin
          entry_wdata = entry_q_r;
          cur_nxt     = cur_m1;
          state_nxt   = S_BRD;
        end else begin
          scan_len_nxt = scan_limit(len_r, top_r);
          iss_nxt      = '0;
          acc_nxt      = '0;
          state_nxt    = S_SUM;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_hit_nxt     = 1'b0;
          o_room_nxt    = 1'b0;
          o_mass_nxt    = '0;
          o_total_nxt   = '0;
          o_drop_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      top_r       <= TOP_RESET;
      iss_r       <= '0;
      d_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      iss_r       <= iss_nxt;
      d_vld_r     <= d_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        top_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    label_r    <= label_nxt;
    leaf_idx_r <= leaf_idx_nxt;
    base_r     <= base_nxt;
    len_r      <= len_nxt;
    scan_len_r <= scan_len_nxt;
    events_r   <= events_nxt;
    acc_r      <= acc_nxt;
    mv_count_r <= mv_count_nxt;
    d_idx_r    <= d_idx_nxt;
    pos_r      <= pos_nxt;
    cur_r      <= cur_nxt;
    hit_r      <= hit_nxt;
    room_r     <= room_nxt;
    found_r    <= found_nxt;
    dropped_r  <= dropped_nxt;
    o_hit_r    <= o_hit_nxt;
    o_room_r   <= o_room_nxt;
    o_mass_r   <= o_mass_nxt;
    o_total_r  <= o_total_nxt;
    o_drop_r   <= o_drop_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = o_hit_r;
  assign out_room       = o_room_r;
  assign out_top_mass   = o_mass_r;
  assign out_leaf_total = o_total_r;
  assign out_dropped    = o_drop_r;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the leaf label frequency table with a built-in table predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import llft_pkg::*;

  localparam int LEAF_NUM      = LEAVES_DEF;
  localparam int SLOTS         = ENTRIES_DEF;
  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int PHASES        = 11;
  localparam int PHASE_ITEMS   = 50;
  localparam int DRAIN_CYCLES  = 200;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DIRECTED_ROWS = 23;

  typedef struct packed {
    logic             hit;
    logic             room;
    logic [CNT_W-1:0] top_mass;
    logic [CNT_W-1:0] leaf_total;
    logic             dropped;
  } outcome_t;

  typedef struct packed {
    logic               is_cfg;
    logic [TOP_W-1:0]   top;
    logic [FUNC_W-1:0]  func;
    logic [LEAF_W-1:0]  leaf;
    logic [LABEL_W-1:0] label;
    logic               typed;
    outcome_t           want;
  } step_row_t;

  localparam outcome_t NO_CHECK = '0;

  // Rows marked typed carry a result that follows directly from the rules;
  // the others are checked against the predictor.
  localparam step_row_t SCRIPT [DIRECTED_ROWS] = '{
    '{1'b0, 6'd0,  FUNC_QUERY,  4'd0,  16'h0000, 1'b1, '{1'b0, 1'b1, 32'd0, 32'd0, 1'b0}},
    '{1'b0, 6'd0,  FUNC_RECORD, 4'd0,  16'h0000, 1'b1, '{1'b0, 1'b1, 32'd1, 32'd1, 1'b0}},
    '{1'b0, 6'd0,  FUNC_RECORD, 4'd0,  16'hFFFF, 1'b1, '{1'b0, 1'b1, 32'd2, 32'd2, 1'b0}},
    '{1'b0, 6'd0,  FUNC_RECORD, 4'd0,  16'hFFFF, 1'b0, NO_CHECK},
    '{1'b0, 6'd0,  FUNC_RECORD, 4'd15, 16'hFFFF, 1'b1, '{1'b0, 1'b1, 32'd1, 32'd1, 1'b0}},
    '{1'b0, 6'd0,  FUNC_RECORD, 4'd0,  16'h5555, 1'b0, NO_CHECK},
    '{1'b0, 6'd0,  FUNC_RECORD, 4'd0,  16'hAAAA, 1'b0, NO_CHECK},
    '{1'b0, 6'd0,  FUNC_RECORD, 4'd0,  16'h1234, 1'b0, NO_CHECK},
    '{1'b0, 6'd0,  FUNC_RECORD, 4'd0,  16'h1234, 1'b0, NO_CHECK},
    '{1'b0, 6'd0,  FUNC_QUERY,  4'd0,  16'h1234, 1'b0, NO_CHECK},
    '{1'b1, 6'd0,  FUNC_QUERY,  4'd0,  16'h0000, 1'b0, NO_CHECK},
    '{1'b0, 6'd0,  FUNC_QUERY,  4'd0,  16'hFFFF, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd7, 1'b0}},
    '{1'b0, 6'd0,  FUNC_RECORD, 4'd0,  16'h0000, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd8, 1'b0}},
    '{1'b1, 6'd63, FUNC_QUERY,  4'd0,  16'h0000, 1'b0, NO_CHECK},
    '{1'b0, 6'd0,  FUNC_QUERY,  4'd0,  16'hAAAA, 1'b0, NO_CHECK},
    '{1'b0, 6'd0,  FUNC_RECORD, 4'd3,  16'h8001, 1'b1, '{1'b0, 1'b1, 32'd1, 32'd1, 1'b0}},
    '{1'b1, 6'd1,  FUNC_QUERY,  4'd0,  16'h0000, 1'b0, NO_CHECK},
    '{1'b0, 6'd0,  FUNC_QUERY,  4'd0,  16'hFFFF, 1'b0, NO_CHECK},
    '{1'b0, 6'd0,  FUNC_RECORD, 4'd0,  16'h0000, 1'b0, NO_CHECK},
    '{1'b1, 6'd32, FUNC_QUERY,  4'd0,  16'h0000, 1'b0, NO_CHECK},
    '{1'b0, 6'd0,  FUNC_QUERY,  4'd7,  16'h0F0F, 1'b1, '{1'b0, 1'b1, 32'd0, 32'd0, 1'b0}},
    '{1'b0, 6'd0,  FUNC_RECORD, 4'd0,  16'h7FFF, 1'b0, NO_CHECK},
    '{1'b1, 6'd4,  FUNC_QUERY,  4'd0,  16'h0000, 1'b0, NO_CHECK}
  };

  localparam logic [TOP_W-1:0] PHASE_TOP [PHASES-1] = '{
    6'd1, 6'd32, 6'd63, 6'd0, 6'd4, 6'd2, 6'd31, 6'd33, 6'd8, 6'd16
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [TOP_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [FUNC_W-1:0]  in_func;
  logic [LEAF_W-1:0]  in_leaf;
  logic [LABEL_W-1:0] in_label;
  logic               out_valid;
  logic               out_stall;
  logic               out_hit;
  logic               out_room;
  logic [CNT_W-1:0]   out_top_mass;
  logic [CNT_W-1:0]   out_leaf_total;
  logic               out_dropped;

  // Predictor copy of the per-leaf lists.
  logic [LABEL_W-1:0] mdl_label [LEAF_NUM][SLOTS];
  logic [CNT_W-1:0]   mdl_count [LEAF_NUM][SLOTS];
  int                 mdl_len [LEAF_NUM];
  logic [CNT_W-1:0]   mdl_events [LEAF_NUM];
  logic [TOP_W-1:0]   mdl_top;

  outcome_t           pending_outcomes [$];
  logic [LABEL_W-1:0] label_salt [LEAF_NUM];
  int unsigned        failures;
  int unsigned        cycle_count;
  bit                 calm;

  leaf_label_frequency_table i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_leaf        (in_leaf),
    .in_label       (in_label),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_room       (out_room),
    .out_top_mass   (out_top_mass),
    .out_leaf_total (out_leaf_total),
    .out_dropped    (out_dropped)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Applies one access to the predicted lists and returns the result it yields.
  function automatic outcome_t table_access(logic [FUNC_W-1:0] func, logic [LEAF_W-1:0] leaf,
                                            logic [LABEL_W-1:0] label);
    outcome_t           o;
    int                 n, lim, pos, i;
    bit                 found;
    logic [CNT_W:0]     acc;
    logic [LABEL_W-1:0] tl;
    logic [CNT_W-1:0]   tc;
    o = '0;
    n = mdl_len[leaf];
    lim = (n < int'(mdl_top)) ? n : int'(mdl_top);
    for (i = 0; i < lim; i++)
      if (mdl_label[leaf][i] == label) o.hit = 1'b1;
    o.room = (n < int'(mdl_top));
    if (func == FUNC_RECORD) begin
      found = 1'b0;
      pos = 0;
      for (i = 0; i < n && !found; i++) begin
        if (mdl_label[leaf][i] == label) begin
          pos = i;
          found = 1'b1;
        end
      end
      if (found) begin
        if (mdl_count[leaf][pos] != '1) mdl_count[leaf][pos]++;
        // Move forward past every entry with a strictly smaller count.
        while (pos > 0 && mdl_count[leaf][pos-1] < mdl_count[leaf][pos]) begin
          tl = mdl_label[leaf][pos-1];
          tc = mdl_count[leaf][pos-1];
          mdl_label[leaf][pos-1] = mdl_label[leaf][pos];
          mdl_count[leaf][pos-1] = mdl_count[leaf][pos];
          mdl_label[leaf][pos] = tl;
          mdl_count[leaf][pos] = tc;
          pos--;
        end
      end else if (n < SLOTS) begin
        mdl_label[leaf][n] = label;
        mdl_count[leaf][n] = CNT_W'(1);
        n++;
        mdl_len[leaf] = n;
      end else begin
        o.dropped = 1'b1;
      end
      if (mdl_events[leaf] != '1) mdl_events[leaf]++;
    end
    lim = (n < int'(mdl_top)) ? n : int'(mdl_top);
    acc = '0;
    for (i = 0; i < lim; i++) begin
      acc = acc + {1'b0, mdl_count[leaf][i]};
      if (acc[CNT_W]) acc = {1'b0, {CNT_W{1'b1}}};
    end
    o.top_mass = acc[CNT_W-1:0];
    o.leaf_total = mdl_events[leaf];
    return o;
  endfunction

  // Called and left just after a falling edge; returns once the beat is taken.
  task automatic send_item(logic [FUNC_W-1:0] func, logic [LEAF_W-1:0] leaf,
                           logic [LABEL_W-1:0] label, logic typed, outcome_t want);
    int unsigned gap;
    outcome_t    predicted;
    gap = idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_leaf  <= leaf;
    in_label <= label;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = table_access(func, leaf, label);
    pending_outcomes.insert(pending_outcomes.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  // The top count is only changed once every outstanding result has come back.
  task automatic set_top(logic [TOP_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    mdl_top = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  initial begin
    step_row_t        row;
    int               r, p, n, span;
    logic [LEAF_W-1:0] leaf;
    logic [FUNC_W-1:0] func;
    logic [LABEL_W-1:0] label;
    logic [31:0]      mix;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = TOP_RESET;
    in_valid  = 1'b0;
    in_func   = FUNC_QUERY;
    in_leaf   = '0;
    in_label  = '0;
    calm      = 1'b0;
    failures  = 0;
    mdl_top   = TOP_RESET;
    for (r = 0; r < LEAF_NUM; r++) begin
      mdl_len[r] = 0;
      mdl_events[r] = '0;
      label_salt[r] = LABEL_W'($urandom);
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < DIRECTED_ROWS; r++) begin
      row = SCRIPT[r];
      if (row.is_cfg) set_top(row.top);
      else send_item(row.func, row.leaf, row.label, row.typed, row.want);
    end

    // Most beats hit a few busy leaves with small label pools, so lists fill up,
    // counts climb and entries reorder; the rest are scattered noise.
    for (p = 0; p < PHASES; p++) begin
      calm = (p % 4 == 2);
      set_top(p < PHASES - 1 ? PHASE_TOP[p] : TOP_W'($urandom_range(0, 63)));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        leaf = (r < 30) ? 4'd0 : (r < 50) ? 4'd3 : LEAF_W'($urandom_range(0, LEAF_NUM - 1));
        func = ($urandom_range(0, 99) < 70) ? FUNC_RECORD : FUNC_QUERY;
        case (leaf[1:0])
          2'd0:    span = 40;
          2'd1:    span = 3;
          2'd2:    span = 12;
          default: span = 36;
        endcase
        if ($urandom_range(0, 99) < 85) begin
          mix = $urandom_range(0, span - 1) * 32'h9E37;
          label = label_salt[leaf] ^ mix[LABEL_W-1:0];
        end else begin
          label = LABEL_W'($urandom);
        end
        send_item(func, leaf, label, 1'b0, NO_CHECK);
      end
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Result side stall pattern.
  initial begin
    int unsigned hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        hold = idle_span();
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("*** FAILED ***");
      $finish;
    end else if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_outcomes.size() == 0) begin
        failures++;
        $display("%0t: result beat with nothing expected: hit %0b room %0b mass %0h total %0h",
                 $time, out_hit, out_room, out_top_mass, out_leaf_total);
      end else begin
        want = pending_outcomes.pop_front();
        check_field("hit", 32'(want.hit), 32'(out_hit));
        check_field("room", 32'(want.room), 32'(out_room));
        check_field("top_mass", want.top_mass, out_top_mass);
        check_field("leaf_total", want.leaf_total, out_leaf_total);
        check_field("dropped", 32'(want.dropped), 32'(out_dropped));
      end
    end
  end

endmodule
